// ===== hw/rtl/cubemap_direction_to_texel_assert.svh =====
// assertion macros shared by the cubemap texel addressing rtl
`ifndef CUBEMAP_DIRECTION_TO_TEXEL_ASSERT_SVH
`define CUBEMAP_DIRECTION_TO_TEXEL_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cubemap texel check failed");

// implication after a fixed number of cycles
`define CDT_ASSERT_LAT(label, clk, rst_n, ante, lat, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(lat) (cons)) \
        else $error("cubemap texel latency check failed");

`endif

// ===== hw/rtl/cdt_pkg.sv =====
// shared types and constants for the cubemap texel addressing pipeline
package cdt_pkg;

    localparam int COMP_W        = 16;   // direction component width
    localparam int MAG_W         = 16;   // magnitude of a component, up to 32768
    localparam int SGN_W         = 17;   // signed projected minor value
    localparam int ACC_W         = 17;   // m + n, 0..2m
    localparam int EDGE_W        = 13;   // configured face edge
    localparam int COORD_W       = 12;   // texel column / row
    localparam int IDX_W         = 24;   // linear texel index
    localparam int NUM_W         = 28;   // dividend (m+n)(E-1)+m
    localparam int DEN_W         = 17;   // divisor 2m
    localparam int FACE_W        = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int DIV_STAGES    = COORD_W;
    localparam int LATENCY       = DIV_STAGES + 3;

    localparam logic [EDGE_W-1:0] MAX_FACE_EDGE = EDGE_W'(4096);
    localparam logic [EDGE_W-1:0] EDGE_RESET    = EDGE_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_FACE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_HEIGHT = 1'd1;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    typedef struct packed {
        logic signed [COMP_W-1:0] dir_x;
        logic signed [COMP_W-1:0] dir_y;
        logic signed [COMP_W-1:0] dir_z;
    } dir_t;

    typedef struct packed {
        logic                 valid_res;
        logic [FACE_W-1:0]    face;
        logic [COORD_W-1:0]   texel_col;
        logic [COORD_W-1:0]   texel_row;
        logic [IDX_W-1:0]     texel_index;
    } texel_t;

    // sideband that rides along with each transaction
    typedef struct packed {
        logic              ok;
        logic [FACE_W-1:0] face;
    } tag_t;

    typedef struct packed {
        tag_t              tag;
        logic [MAG_W-1:0]  mag;
        logic [ACC_W-1:0]  a_col;
        logic [ACC_W-1:0]  a_row;
    } sel_t;

    typedef struct packed {
        tag_t              tag;
        logic [NUM_W-1:0]  num_col;
        logic [NUM_W-1:0]  num_row;
        logic [DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        tag_t               tag;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } div_res_t;

endpackage

// ===== hw/rtl/cubemap_direction_to_texel.sv =====
// top level of the cubemap face selection and nearest texel addressing pipeline
//
// channel   | dir | handshake               | payload
// ----------+-----+-------------------------+----------------------------------
// request   | in  | start, accepted if !busy| dir_x, dir_y, dir_z
// result    | out | done, one-cycle strobe  | valid_res, face, col, row, index
// config    | in  | cfg_we, no wait         | cfg_index, cfg_data
//
// one transaction may enter every cycle; busy stays low
// stages in order: face select, scale multiply, 12 divider stages
// (one quotient bit each), index multiply and the result register
// reset clears the valid bits of every stage and loads both edges with 64
// no stall path: the receiver always takes done, so nothing is held back
`include "cubemap_direction_to_texel_assert.svh"

module cubemap_direction_to_texel (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  cdt_pkg::dir_t                   request,
    output logic                            done,
    output cdt_pkg::texel_t                 result,
    input  logic                            cfg_we,
    input  logic [cdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cdt_pkg::EDGE_W-1:0]      cfg_data
);

    // configuration registers
    logic [cdt_pkg::EDGE_W-1:0]  face_width_reg, face_width_next;
    logic [cdt_pkg::EDGE_W-1:0]  face_height_reg, face_height_next;

    // saturated edges and derived values
    logic [cdt_pkg::EDGE_W-1:0]  w_eff, h_eff, w_dec, h_dec;
    logic [cdt_pkg::COORD_W-1:0] w_m1, h_m1;
    logic                        cfg_ok;

    // stage links
    logic                        sel_valid, req_valid, res_valid;
    cdt_pkg::sel_t               sel;
    cdt_pkg::div_req_t           req;
    cdt_pkg::div_res_t           res;

    // config must be written only while no transaction is in flight; the block does not enforce it
    always_comb
    begin
        face_width_next  = face_width_reg;
        face_height_next = face_height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                cdt_pkg::CFG_FACE_WIDTH:  face_width_next  = cfg_data;
                cdt_pkg::CFG_FACE_HEIGHT: face_height_next = cfg_data;
                default:                  face_width_next  = face_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_width_reg  <= cdt_pkg::EDGE_RESET;
            face_height_reg <= cdt_pkg::EDGE_RESET;
        end
        else
        begin
            face_width_reg  <= face_width_next;
            face_height_reg <= face_height_next;
        end
    end

    // edges above the largest face are clamped
    always_comb
    begin
        w_eff  = (face_width_reg  > cdt_pkg::MAX_FACE_EDGE) ? cdt_pkg::MAX_FACE_EDGE
                                                            : face_width_reg;
        h_eff  = (face_height_reg > cdt_pkg::MAX_FACE_EDGE) ? cdt_pkg::MAX_FACE_EDGE
                                                            : face_height_reg;
        w_dec  = w_eff - cdt_pkg::EDGE_W'(1);
        h_dec  = h_eff - cdt_pkg::EDGE_W'(1);
        w_m1   = w_dec[cdt_pkg::COORD_W-1:0];
        h_m1   = h_dec[cdt_pkg::COORD_W-1:0];
        cfg_ok = (w_eff != '0) && (h_eff != '0);
    end

    // fully pipelined, never refuses a transaction
    assign busy = 1'b0;

    cdt_face_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .dir       (request),
        .cfg_ok    (cfg_ok),
        .sel_valid (sel_valid),
        .sel       (sel)
    );

    cdt_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .sel_valid (sel_valid),
        .sel       (sel),
        .w_m1      (w_m1),
        .h_m1      (h_m1),
        .req_valid (req_valid),
        .req       (req)
    );

    cdt_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    cdt_addr u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .w_eff     (w_eff),
        .done      (done),
        .result    (result)
    );

    // every accepted transaction comes out a fixed time later
    `CDT_ASSERT_LAT(a_latency, clk, rst_n, start && !busy, cdt_pkg::LATENCY, done)
    // a valid column always lies inside the face row
    `CDT_ASSERT_IMP(a_col_range, clk, rst_n, done && result.valid_res,
                    {1'b0, result.texel_col} < w_eff)
    // a valid row always lies inside the face
    `CDT_ASSERT_IMP(a_row_range, clk, rst_n, done && result.valid_res,
                    {1'b0, result.texel_row} < h_eff)
    // an invalid result carries all-zero fields
    `CDT_ASSERT_IMP(a_invalid_zero, clk, rst_n, done && !result.valid_res,
                    result.face == '0 && result.texel_col == '0 &&
                    result.texel_row == '0 && result.texel_index == '0)

endmodule

// ===== hw/rtl/cdt_face_select.sv =====
// major axis selection and projection onto the chosen face
module cdt_face_select (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  cdt_pkg::dir_t   dir,
    input  logic            cfg_ok,
    output logic            sel_valid,
    output cdt_pkg::sel_t   sel
);

    logic signed [cdt_pkg::SGN_W-1:0] xe, ye, ze;
    logic signed [cdt_pkg::SGN_W-1:0] xn, yn, zn;
    logic [cdt_pkg::SGN_W-1:0]        ax17, ay17, az17;
    logic [cdt_pkg::MAG_W-1:0]        ax, ay, az, m;
    logic signed [cdt_pkg::SGN_W-1:0] u, v;
    logic [cdt_pkg::FACE_W-1:0]       face;
    logic signed [cdt_pkg::ACC_W:0]   sum_col, sum_row;
    logic                             valid_reg;
    cdt_pkg::sel_t                    sel_reg, sel_next;

    always_comb
    begin
        xe = cdt_pkg::SGN_W'(dir.dir_x);
        ye = cdt_pkg::SGN_W'(dir.dir_y);
        ze = cdt_pkg::SGN_W'(dir.dir_z);
        xn = -xe;
        yn = -ye;
        zn = -ze;
        ax17 = dir.dir_x[cdt_pkg::COMP_W-1] ? xn : xe;
        ay17 = dir.dir_y[cdt_pkg::COMP_W-1] ? yn : ye;
        az17 = dir.dir_z[cdt_pkg::COMP_W-1] ? zn : ze;
        ax = ax17[cdt_pkg::MAG_W-1:0];
        ay = ay17[cdt_pkg::MAG_W-1:0];
        az = az17[cdt_pkg::MAG_W-1:0];

        // tie order x, then y, then z; zero counts as positive
        if (ax >= ay && ax >= az)
        begin
            m = ax;
            v = ye;
            if (!dir.dir_x[cdt_pkg::COMP_W-1])
            begin
                face = cdt_pkg::FACE_POS_X;
                u    = zn;
            end
            else
            begin
                face = cdt_pkg::FACE_NEG_X;
                u    = ze;
            end
        end
        else if (ay >= az)
        begin
            m = ay;
            u = xe;
            if (!dir.dir_y[cdt_pkg::COMP_W-1])
            begin
                face = cdt_pkg::FACE_POS_Y;
                v    = zn;
            end
            else
            begin
                face = cdt_pkg::FACE_NEG_Y;
                v    = ze;
            end
        end
        else
        begin
            m = az;
            v = ye;
            if (!dir.dir_z[cdt_pkg::COMP_W-1])
            begin
                face = cdt_pkg::FACE_POS_Z;
                u    = xe;
            end
            else
            begin
                face = cdt_pkg::FACE_NEG_Z;
                u    = xn;
            end
        end

        sum_col = $signed({2'b00, m}) + (cdt_pkg::ACC_W+1)'(u);
        sum_row = $signed({2'b00, m}) - (cdt_pkg::ACC_W+1)'(v);

        sel_next.tag.ok   = cfg_ok && ((ax | ay | az) != '0);
        sel_next.tag.face = face;
        sel_next.mag      = m;
        sel_next.a_col    = sum_col[cdt_pkg::ACC_W-1:0];
        sel_next.a_row    = sum_row[cdt_pkg::ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
    end

    assign sel_valid = valid_reg;
    assign sel       = sel_reg;

endmodule

// ===== hw/rtl/cdt_scale.sv =====
// scales the projected values by the face edge to form the dividends
module cdt_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sel_valid,
    input  cdt_pkg::sel_t                sel,
    input  logic [cdt_pkg::COORD_W-1:0]  w_m1,
    input  logic [cdt_pkg::COORD_W-1:0]  h_m1,
    output logic                         req_valid,
    output cdt_pkg::div_req_t            req
);

    logic              valid_reg;
    cdt_pkg::div_req_t req_reg, req_next;

    always_comb
    begin
        req_next.tag     = sel.tag;
        // (m+n)(E-1) + m, always below 2^28
        req_next.num_col = cdt_pkg::NUM_W'(sel.a_col) * cdt_pkg::NUM_W'(w_m1)
                         + cdt_pkg::NUM_W'(sel.mag);
        req_next.num_row = cdt_pkg::NUM_W'(sel.a_row) * cdt_pkg::NUM_W'(h_m1)
                         + cdt_pkg::NUM_W'(sel.mag);
        req_next.den     = {sel.mag, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= sel_valid;
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

// ===== hw/rtl/cdt_div_pipe.sv =====
// two-lane restoring divider, one quotient bit per stage
module cdt_div_pipe (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  cdt_pkg::div_req_t   req,
    output logic                res_valid,
    output cdt_pkg::div_res_t   res
);

    localparam int S = cdt_pkg::DIV_STAGES;

    logic                         valid_reg [S];
    cdt_pkg::tag_t                tag_reg   [S];
    logic [cdt_pkg::DEN_W-1:0]    den_reg   [S];
    logic [cdt_pkg::NUM_W-1:0]    rc_reg    [S];
    logic [cdt_pkg::NUM_W-1:0]    rr_reg    [S];
    logic [cdt_pkg::COORD_W-1:0]  qc_reg    [S];
    logic [cdt_pkg::COORD_W-1:0]  qr_reg    [S];

    logic [cdt_pkg::DEN_W-1:0]    den_src   [S];
    logic [cdt_pkg::NUM_W-1:0]    rc_src    [S];
    logic [cdt_pkg::NUM_W-1:0]    rr_src    [S];
    logic [cdt_pkg::COORD_W-1:0]  qc_src    [S];
    logic [cdt_pkg::COORD_W-1:0]  qr_src    [S];
    logic [cdt_pkg::NUM_W-1:0]    rc_next   [S];
    logic [cdt_pkg::NUM_W-1:0]    rr_next   [S];
    logic [cdt_pkg::COORD_W-1:0]  qc_next   [S];
    logic [cdt_pkg::COORD_W-1:0]  qr_next   [S];

    // trial subtract; top bit set means the shifted divisor did not fit
    function automatic logic [cdt_pkg::NUM_W:0] trial(
        input logic [cdt_pkg::NUM_W-1:0] rem,
        input logic [cdt_pkg::DEN_W-1:0] den,
        input int                        sh
    );
        logic [cdt_pkg::NUM_W:0] dsh;
        dsh = (cdt_pkg::NUM_W+1)'(den) << sh;
        return {1'b0, rem} - dsh;
    endfunction

    always_comb
    begin
        den_src[0] = req.den;
        rc_src[0]  = req.num_col;
        rr_src[0]  = req.num_row;
        qc_src[0]  = '0;
        qr_src[0]  = '0;
        for (int s = 1; s < S; s++)
        begin
            den_src[s] = den_reg[s-1];
            rc_src[s]  = rc_reg[s-1];
            rr_src[s]  = rr_reg[s-1];
            qc_src[s]  = qc_reg[s-1];
            qr_src[s]  = qr_reg[s-1];
        end
    end

    always_comb
    begin
        logic [cdt_pkg::NUM_W:0] dc, dr;
        for (int s = 0; s < S; s++)
        begin
            dc = trial(rc_src[s], den_src[s], cdt_pkg::COORD_W - 1 - s);
            dr = trial(rr_src[s], den_src[s], cdt_pkg::COORD_W - 1 - s);
            rc_next[s] = dc[cdt_pkg::NUM_W] ? rc_src[s] : dc[cdt_pkg::NUM_W-1:0];
            rr_next[s] = dr[cdt_pkg::NUM_W] ? rr_src[s] : dr[cdt_pkg::NUM_W-1:0];
            qc_next[s] = qc_src[s];
            qr_next[s] = qr_src[s];
            qc_next[s][cdt_pkg::COORD_W-1-s] = !dc[cdt_pkg::NUM_W];
            qr_next[s][cdt_pkg::COORD_W-1-s] = !dr[cdt_pkg::NUM_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < S; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= req_valid;
            for (int s = 1; s < S; s++)
                valid_reg[s] <= valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= req.tag;
        for (int s = 1; s < S; s++)
            tag_reg[s] <= tag_reg[s-1];
        for (int s = 0; s < S; s++)
        begin
            den_reg[s] <= den_src[s];
            rc_reg[s]  <= rc_next[s];
            rr_reg[s]  <= rr_next[s];
            qc_reg[s]  <= qc_next[s];
            qr_reg[s]  <= qr_next[s];
        end
    end

    assign res_valid = valid_reg[S-1];
    assign res.tag   = tag_reg[S-1];
    assign res.col   = qc_reg[S-1];
    assign res.row   = qr_reg[S-1];

endmodule

// ===== hw/rtl/cdt_addr.sv =====
// linear texel index and the result register
module cdt_addr (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         res_valid,
    input  cdt_pkg::div_res_t            res,
    input  logic [cdt_pkg::EDGE_W-1:0]   w_eff,
    output logic                         done,
    output cdt_pkg::texel_t              result
);

    logic            done_reg;
    cdt_pkg::texel_t out_reg, out_next;

    always_comb
    begin
        out_next = '0;
        if (res.tag.ok)
        begin
            out_next.valid_res   = 1'b1;
            out_next.face        = res.tag.face;
            out_next.texel_col   = res.col;
            out_next.texel_row   = res.row;
            out_next.texel_index = cdt_pkg::IDX_W'(res.row) * cdt_pkg::IDX_W'(w_eff)
                                 + cdt_pkg::IDX_W'(res.col);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

// ===== bench/cubemap_direction_to_texel_test.sv =====
// self-checking testbench for the cubemap direction to texel addressing block
module cubemap_direction_to_texel_test;
    timeunit 1ns;
    timeprecision 1ps;

    // run length guard, far above the slowest legal run
    localparam int CYCLE_LIMIT   = 300000;
    // pipeline depth from the package, plus a little slack
    localparam int DRAIN_CYCLES  = cdt_pkg::LATENCY + 5;
    localparam int N_DIRECTED    = 22;
    localparam int N_FIXED       = 9;
    localparam int N_RANDOM_SIZE = 3;

    // expected-address store: keeps its own copy of the two face edges,
    // predicts each accepted direction and matches results in order
    class texel_scoreboard;
        logic [cdt_pkg::EDGE_W-1:0] face_width;
        logic [cdt_pkg::EDGE_W-1:0] face_height;
        cdt_pkg::texel_t            expected_q[$];
        int                         errors;
        int                         checked;

        function new();
            face_width  = cdt_pkg::EDGE_RESET;
            face_height = cdt_pkg::EDGE_RESET;
            errors      = 0;
            checked     = 0;
        endfunction

        function void set_edge(logic [cdt_pkg::CFG_IDX_W-1:0] idx, int value);
            if (idx == cdt_pkg::CFG_FACE_WIDTH)
                face_width = cdt_pkg::EDGE_W'(value);
            else
                face_height = cdt_pkg::EDGE_W'(value);
        endfunction

        // nearest texel for one direction, exact integer math
        function cdt_pkg::texel_t predict(cdt_pkg::dir_t d);
            longint x, y, z, ax, ay, az;
            longint m, u, v, w, h, col, row;
            cdt_pkg::texel_t t;
            t = '0;
            x = longint'(d.dir_x);
            y = longint'(d.dir_y);
            z = longint'(d.dir_z);
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            az = (z < 0) ? -z : z;
            // edges above the supported maximum saturate
            w = (face_width  > cdt_pkg::MAX_FACE_EDGE) ? cdt_pkg::MAX_FACE_EDGE : face_width;
            h = (face_height > cdt_pkg::MAX_FACE_EDGE) ? cdt_pkg::MAX_FACE_EDGE : face_height;
            if ((ax | ay | az) == 0 || w == 0 || h == 0)
                return t;
            // major axis: x wins ties over y, y over z; zero counts positive
            if (ax >= ay && ax >= az) begin
                m = ax;
                v = y;
                if (x >= 0) begin
                    t.face = cdt_pkg::FACE_POS_X;
                    u = -z;
                end
                else begin
                    t.face = cdt_pkg::FACE_NEG_X;
                    u = z;
                end
            end
            else if (ay >= az) begin
                m = ay;
                u = x;
                if (y >= 0) begin
                    t.face = cdt_pkg::FACE_POS_Y;
                    v = -z;
                end
                else begin
                    t.face = cdt_pkg::FACE_NEG_Y;
                    v = z;
                end
            end
            else begin
                m = az;
                v = y;
                if (z >= 0) begin
                    t.face = cdt_pkg::FACE_POS_Z;
                    u = x;
                end
                else begin
                    t.face = cdt_pkg::FACE_NEG_Z;
                    u = -x;
                end
            end
            // round half up: floor(((m+n)(E-1) + m) / 2m)
            col = ((m + u) * (w - 1) + m) / (2 * m);
            row = ((m - v) * (h - 1) + m) / (2 * m);
            t.valid_res   = 1'b1;
            t.texel_col   = cdt_pkg::COORD_W'(col);
            t.texel_row   = cdt_pkg::COORD_W'(row);
            t.texel_index = cdt_pkg::IDX_W'(col + row * w);
            return t;
        endfunction

        function void note_request(cdt_pkg::dir_t d);
            expected_q.push_back(predict(d));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            errors++;
            $display("error @%0t: %s", $realtime, msg);
        endtask

        task check_field(string field, longint got, longint want);
            if (got != want)
                report($sformatf("transaction %0d %s: got %0d expected %0d",
                                 checked, field, got, want));
        endtask

        task check_result(cdt_pkg::texel_t got);
            cdt_pkg::texel_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with no transaction outstanding, index %0d",
                                 got.texel_index));
                return;
            end
            want = expected_q.pop_front();
            check_field("valid_res",   got.valid_res,   want.valid_res);
            check_field("face",        got.face,        want.face);
            check_field("texel_col",   got.texel_col,   want.texel_col);
            check_field("texel_row",   got.texel_row,   want.texel_row);
            check_field("texel_index", got.texel_index, want.texel_index);
            checked++;
        endtask
    endclass

    // ---------------------------------------------------------------
    // block ports
    // ---------------------------------------------------------------
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          start     = 1'b0;
    logic                          busy;
    cdt_pkg::dir_t                 request   = '0;
    logic                          done;
    cdt_pkg::texel_t               result;
    logic                          cfg_we    = 1'b0;
    logic [cdt_pkg::CFG_IDX_W-1:0] cfg_index = cdt_pkg::CFG_FACE_WIDTH;
    logic [cdt_pkg::EDGE_W-1:0]    cfg_data  = '0;

    texel_scoreboard sb = new();

    // run statistics for the closing summary
    int       cycles      = 0;
    int       n_valid     = 0;
    int       n_invalid   = 0;
    int       n_settings  = 0;
    logic [5:0] faces_seen = '0;

    // hand-picked directions: each face, axis ties, zero vector,
    // most negative and most positive components, rounding ties
    int directed_dirs [N_DIRECTED][3] = '{
        '{0, 0, 0},
        '{1, 0, 0}, '{-1, 0, 0}, '{0, 1, 0}, '{0, -1, 0}, '{0, 0, 1}, '{0, 0, -1},
        '{5, 5, 5}, '{0, 7, 7}, '{-3, 3, 0}, '{2, -9, -9}, '{1, -1, 1},
        '{-32768, -32768, -32768}, '{32767, -32768, 0}, '{0, 0, -32768},
        '{32767, 32767, 32767}, '{-32768, 32767, -32767}, '{-32768, 0, 32767},
        '{2, 1, -1}, '{-2, -1, 1}, '{100, -100, 50}, '{7, -3, 32767}
    };

    // face size settings walked after the directed part; zero and
    // oversized edges included, three more are drawn at random
    int fixed_w [N_FIXED] = '{64, 1, 4096, 8191, 0, 64, 4097, 3, 0};
    int fixed_h [N_FIXED] = '{64, 1, 4096, 8191, 64, 0, 2, 4095, 0};

    cubemap_direction_to_texel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // monitor: everything sampled on the rising edge, inputs were set
    // on the falling edge so they are stable here
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n) begin
            // a transaction enters when start meets a low busy
            if (start && !busy)
                sb.note_request(request);
            // results are strobed for one cycle and cannot be held off
            if (done) begin
                sb.check_result(result);
                if (result.valid_res) begin
                    n_valid++;
                    if (result.face <= cdt_pkg::FACE_NEG_Z)
                        faces_seen[result.face] = 1'b1;
                end
                else begin
                    n_invalid++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending());
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // signed component of a given magnitude; a magnitude of 32768
    // always comes out as -32768, which keeps the same magnitude
    function logic signed [cdt_pkg::COMP_W-1:0] comp(int mag, bit neg);
        return cdt_pkg::COMP_W'(neg ? -mag : mag);
    endfunction

    function cdt_pkg::dir_t mk_dir(int x, int y, int z);
        cdt_pkg::dir_t d;
        d.dir_x = cdt_pkg::COMP_W'(x);
        d.dir_y = cdt_pkg::COMP_W'(y);
        d.dir_z = cdt_pkg::COMP_W'(z);
        return d;
    endfunction

    function logic signed [cdt_pkg::COMP_W-1:0] edge_value();
        case ($urandom_range(0, 6))
            0:       return comp(32768, 1'b1);
            1:       return comp(32767, 1'b1);
            2:       return comp(1, 1'b1);
            3:       return '0;
            4:       return comp(1, 1'b0);
            5:       return comp(32766, 1'b0);
            default: return comp(32767, 1'b0);
        endcase
    endfunction

    // random direction with a mix of shapes: full range, tiny vectors,
    // ties between axes, edge values, one dominant axis, reduced scale
    function cdt_pkg::dir_t rand_dir();
        cdt_pkg::dir_t d;
        int   mag;
        int   axis;
        d.dir_x = cdt_pkg::COMP_W'($urandom);
        d.dir_y = cdt_pkg::COMP_W'($urandom);
        d.dir_z = cdt_pkg::COMP_W'($urandom);
        case ($urandom_range(0, 9))
            4: begin
                d.dir_x = comp($urandom_range(0, 3), $urandom_range(0, 1));
                d.dir_y = comp($urandom_range(0, 3), $urandom_range(0, 1));
                d.dir_z = comp($urandom_range(0, 3), $urandom_range(0, 1));
            end
            5: begin
                // two or three axes share the largest magnitude
                mag  = $urandom_range(1, 32768);
                axis = $urandom_range(0, 3);
                d.dir_x = comp(axis == 0 ? $urandom_range(0, mag - 1) : mag,
                               $urandom_range(0, 1));
                d.dir_y = comp(axis == 1 ? $urandom_range(0, mag - 1) : mag,
                               $urandom_range(0, 1));
                d.dir_z = comp(axis == 2 ? $urandom_range(0, mag - 1) : mag,
                               $urandom_range(0, 1));
            end
            6: begin
                d.dir_x = edge_value();
                d.dir_y = edge_value();
                d.dir_z = edge_value();
            end
            7: begin
                // one axis strictly dominant
                mag  = $urandom_range(1, 32768);
                axis = $urandom_range(0, 2);
                d.dir_x = comp(axis == 0 ? mag : $urandom_range(0, mag - 1),
                               $urandom_range(0, 1));
                d.dir_y = comp(axis == 1 ? mag : $urandom_range(0, mag - 1),
                               $urandom_range(0, 1));
                d.dir_z = comp(axis == 2 ? mag : $urandom_range(0, mag - 1),
                               $urandom_range(0, 1));
            end
            8: begin
                d.dir_x = d.dir_x >>> $urandom_range(0, 15);
                d.dir_y = d.dir_y >>> $urandom_range(0, 15);
                d.dir_z = d.dir_z >>> $urandom_range(0, 15);
            end
            default: ;
        endcase
        return d;
    endfunction

    // present one transaction from a falling edge and hold it until taken;
    // start stays high on return so a following item needs no re-raise
    task send_item(cdt_pkg::dir_t d);
        start   <= 1'b1;
        request <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drop start and wait for every outstanding result
    task wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // both edges written on consecutive cycles while the pipe is empty
    task set_face_size(int w, int h);
        cfg_we    <= 1'b1;
        cfg_index <= cdt_pkg::CFG_FACE_WIDTH;
        cfg_data  <= cdt_pkg::EDGE_W'(w);
        sb.set_edge(cdt_pkg::CFG_FACE_WIDTH, w);
        @(negedge clk);
        cfg_index <= cdt_pkg::CFG_FACE_HEIGHT;
        cfg_data  <= cdt_pkg::EDGE_W'(h);
        sb.set_edge(cdt_pkg::CFG_FACE_HEIGHT, h);
        @(negedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // random directions in bursts of random length; gaps of zero give
    // back-to-back stretches, longer gaps land on every pipeline stage
    task run_random(int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < count) begin
                send_item(rand_dir());
                sent++;
                burst--;
            end
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 20);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int i;
        int w;
        int h;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part back to back at the reset face size
        set_face_size(64, 64);
        for (i = 0; i < N_DIRECTED; i++)
            send_item(mk_dir(directed_dirs[i][0], directed_dirs[i][1],
                             directed_dirs[i][2]));
        wait_drained();

        // random part, one phase per face size; invalid sizes get fewer items
        for (i = 0; i < N_FIXED + N_RANDOM_SIZE; i++) begin
            if (i < N_FIXED) begin
                w = fixed_w[i];
                h = fixed_h[i];
            end
            else begin
                w = $urandom_range(1, 4096);
                h = $urandom_range(1, 4096);
            end
            set_face_size(w, h);
            run_random((w == 0 || h == 0) ? 30 : 105);
            wait_drained();
        end

        // let any stray strobe show up before judging
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d transactions over %0d face size settings",
                 sb.checked, n_settings);
        $display("%0d valid and %0d invalid addresses, faces seen %b, %0d errors",
                 n_valid, n_invalid, faces_seen, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
